// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; users provide clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define BADS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define BADS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/badseq_pkg.sv
// Types and constants of the boundary-avoid drive sequencer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package badseq_pkg;

  localparam int unsigned SpeedW = 8;
  localparam int unsigned TickW  = 8;
  localparam int unsigned PctW   = 7;
  localparam int unsigned ProdW  = 16;

  localparam logic [SpeedW-1:0] SpeedMax  = 8'd150;
  localparam logic [TickW-1:0]  TickMax   = 8'hFF;
  localparam logic [7:0]        BoostBase = 8'd100;

  // Right speed divide by 100: x / 100 == (x * 5243) >> 19 for x < 43690.
  // Products at or above 151 * 100 clamp anyway.
  localparam int unsigned       DivRecip  = 5243;
  localparam int unsigned       DivShift  = 19;
  localparam int unsigned       QuotW     = 27;
  localparam int unsigned       SmallW    = 14;
  localparam logic [ProdW-1:0]  ClampProd = 16'((150 + 1) * 100);

  localparam logic [7:0]        RstForwardSpeed = 8'd70;
  localparam logic [7:0]        RstReverseSpeed = 8'd70;
  localparam logic [7:0]        RstSpinSpeed    = 8'd70;
  localparam logic [PctW-1:0]   RstBoostPct     = 7'd15;
  localparam logic [7:0]        RstBrakeTicks   = 8'd3;
  localparam logic [7:0]        RstReverseTicks = 8'd15;
  localparam logic [7:0]        RstSpinTicks    = 8'd50;
  localparam logic [7:0]        RstHitNeeded    = 8'd2;

  typedef enum logic [2:0] {
    CFG_FORWARD_SPEED    = 3'd0,
    CFG_REVERSE_SPEED    = 3'd1,
    CFG_SPIN_SPEED       = 3'd2,
    CFG_RIGHT_BOOST_PCT  = 3'd3,
    CFG_BRAKE_TICKS      = 3'd4,
    CFG_REVERSE_TICKS    = 3'd5,
    CFG_SPIN_TICKS       = 3'd6,
    CFG_HIT_COUNT_NEEDED = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_START = 1'b1
  } req_e;

  typedef enum logic [4:0] {
    MODE_STOP  = 5'b00001,
    MODE_FWD   = 5'b00010,
    MODE_BRAKE = 5'b00100,
    MODE_BACK  = 5'b01000,
    MODE_TURN  = 5'b10000
  } mode_e;

  typedef enum logic [2:0] {
    FR_STOP   = 3'd0,
    FR_FWD    = 3'd1,
    FR_BACK   = 3'd2,
    FR_TURN_L = 3'd3,
    FR_TURN_R = 3'd4
  } frame_e;

  typedef struct packed {
    logic [SpeedW-1:0] forward_speed;
    logic [SpeedW-1:0] reverse_speed;
    logic [SpeedW-1:0] spin_speed;
    logic [PctW-1:0]   right_boost_pct;
    logic [TickW-1:0]  brake_ticks;
    logic [TickW-1:0]  reverse_ticks;
    logic [TickW-1:0]  spin_ticks;
    logic [7:0]        hit_count_needed;
  } cfg_t;

  typedef struct packed {
    logic req_type;
    logic left_on_line;
    logic right_on_line;
    logic random_left;
  } in_item_t;

  typedef struct packed {
    logic              left_reverse;
    logic [SpeedW-1:0] left_speed;
    logic              right_reverse;
    logic [SpeedW-1:0] right_speed;
    logic              last;
  } out_item_t;

  // Frames caused by one input transaction, oldest in slot 0.
  typedef struct packed {
    frame_e [2:0] frames;
    logic   [1:0] cnt;
  } cmd_t;

endpackage

// File: rtl/core/boundary_avoid_drive_sequencer_core.sv
// Boundary-avoid drive sequencer: takes one tick or start transaction per cycle and emits
// zero to three motor frames for it, one frame per cycle while the output is not stalled, the
// last one flagged. The front end updates the mode state in the cycle a transaction is accepted
// and hands a frame command to a two-entry queue; the back end turns each command into frames
// through a two-stage pipeline (boost multiply, then divide by 100 and clamp), so a frame
// passes the queue, the stage-one register and the output register, and a transaction's frames
// leave one after another. Sustained rate is set by that single frame pipeline. Input stalls
// only when the queue is full. Configuration writes are always ready and take effect at once.
// Depends on badseq_pkg, badseq_front, badseq_cmdq, badseq_back.
`timescale 1ns / 1ps

module boundary_avoid_drive_sequencer_core #(
  parameter int unsigned KEEPALIVE_PERIOD = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  badseq_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output badseq_pkg::out_item_t out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i
);
  import badseq_pkg::*;

  cfg_t cfg_q;
  logic q_full, q_valid, push, pop;
  cmd_t push_cmd, head_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.forward_speed    <= RstForwardSpeed;
      cfg_q.reverse_speed    <= RstReverseSpeed;
      cfg_q.spin_speed       <= RstSpinSpeed;
      cfg_q.right_boost_pct  <= RstBoostPct;
      cfg_q.brake_ticks      <= RstBrakeTicks;
      cfg_q.reverse_ticks    <= RstReverseTicks;
      cfg_q.spin_ticks       <= RstSpinTicks;
      cfg_q.hit_count_needed <= RstHitNeeded;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FORWARD_SPEED:    cfg_q.forward_speed    <= cfg_data_i;
        CFG_REVERSE_SPEED:    cfg_q.reverse_speed    <= cfg_data_i;
        CFG_SPIN_SPEED:       cfg_q.spin_speed       <= cfg_data_i;
        CFG_RIGHT_BOOST_PCT:  cfg_q.right_boost_pct  <= cfg_data_i[PctW-1:0];
        CFG_BRAKE_TICKS:      cfg_q.brake_ticks      <= cfg_data_i;
        CFG_REVERSE_TICKS:    cfg_q.reverse_ticks    <= cfg_data_i;
        CFG_SPIN_TICKS:       cfg_q.spin_ticks       <= cfg_data_i;
        CFG_HIT_COUNT_NEEDED: cfg_q.hit_count_needed <= cfg_data_i;
        default: ;
      endcase
    end
  end

  badseq_front #(
    .KEEPALIVE_PERIOD(KEEPALIVE_PERIOD)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .q_full_i  (q_full),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  badseq_cmdq u_cmdq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (q_full),
    .pop_i     (pop),
    .valid_o   (q_valid),
    .head_o    (head_cmd)
  );

  badseq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_head_i   (head_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: rtl/core/badseq_front.sv
// Front end: accepts transactions, runs the mode sequencer, queues frame commands.
// Depends on badseq_pkg.
`timescale 1ns / 1ps

module badseq_front #(
  parameter int unsigned KEEPALIVE_PERIOD = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  badseq_pkg::in_item_t in_data_i,
  input  badseq_pkg::cfg_t     cfg_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output badseq_pkg::cmd_t     cmd_o
);
  import badseq_pkg::*;

  localparam int unsigned      PhW      = $clog2(KEEPALIVE_PERIOD + 1);
  localparam logic [PhW-1:0]   PhPeriod = PhW'(KEEPALIVE_PERIOD);

  mode_e            mode_q, mode_d;
  logic [TickW-1:0] ticks_q, ticks_d, ticks_inc;
  logic [PhW-1:0]   phase_q, phase_d, phase_inc;
  logic [7:0]       hits_q, hits_d, hits_inc;
  logic             left_q, left_d;
  logic             accept, ka, hit;
  frame_e [2:0]     fr_d;
  logic [1:0]       nfr;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign ticks_inc  = (ticks_q == TickMax) ? ticks_q : ticks_q + 8'd1;
  assign hits_inc   = (hits_q == 8'hFF) ? hits_q : hits_q + 8'd1;
  assign phase_inc  = phase_q + PhW'(1);
  assign ka         = (phase_inc >= PhPeriod);
  assign hit        = in_data_i.left_on_line | in_data_i.right_on_line;

  always_comb begin
    mode_d  = mode_q;
    ticks_d = ticks_q;
    phase_d = phase_q;
    hits_d  = hits_q;
    left_d  = left_q;
    fr_d    = {FR_STOP, FR_STOP, FR_STOP};
    nfr     = 2'd0;
    if (in_data_i.req_type == REQ_START) begin
      mode_d  = MODE_FWD;
      ticks_d = '0;
      phase_d = '0;
      hits_d  = '0;
      fr_d[0] = FR_FWD;
      nfr     = 2'd1;
    end else begin
      ticks_d = ticks_inc;
      phase_d = ka ? '0 : phase_inc;
      if (ka) begin
        unique case (mode_q)
          MODE_FWD: begin
            fr_d[nfr] = FR_FWD;
            nfr = nfr + 2'd1;
          end
          MODE_STOP, MODE_BRAKE: begin
            fr_d[nfr] = FR_STOP;
            nfr = nfr + 2'd1;
          end
          MODE_BACK: begin
            fr_d[nfr] = FR_BACK;
            nfr = nfr + 2'd1;
          end
          default: ;
        endcase
      end
      unique case (mode_q)
        MODE_STOP: ;
        MODE_FWD: begin
          if (hit) begin
            hits_d = hits_inc;
            if (hits_inc >= cfg_i.hit_count_needed) begin
              mode_d    = MODE_BRAKE;
              ticks_d   = '0;
              phase_d   = '0;
              hits_d    = '0;
              fr_d[nfr] = FR_STOP;
              nfr       = nfr + 2'd1;
            end
          end else begin
            hits_d = '0;
          end
        end
        MODE_BRAKE: begin
          if (ticks_inc >= cfg_i.brake_ticks) begin
            mode_d    = MODE_BACK;
            ticks_d   = '0;
            phase_d   = '0;
            fr_d[nfr] = FR_BACK;
            nfr       = nfr + 2'd1;
          end
        end
        MODE_BACK: begin
          fr_d[nfr] = FR_BACK;
          nfr       = nfr + 2'd1;
          if (ticks_inc >= cfg_i.reverse_ticks) begin
            left_d    = in_data_i.random_left;
            mode_d    = MODE_TURN;
            ticks_d   = '0;
            phase_d   = '0;
            fr_d[nfr] = in_data_i.random_left ? FR_TURN_L : FR_TURN_R;
            nfr       = nfr + 2'd1;
          end
        end
        MODE_TURN: begin
          fr_d[nfr] = left_q ? FR_TURN_L : FR_TURN_R;
          nfr       = nfr + 2'd1;
          if (ticks_inc >= cfg_i.spin_ticks) begin
            mode_d    = MODE_FWD;
            ticks_d   = '0;
            phase_d   = '0;
            hits_d    = '0;
            fr_d[nfr] = FR_FWD;
            nfr       = nfr + 2'd1;
          end
        end
        default: begin
          fr_d[nfr] = FR_STOP;
          nfr       = nfr + 2'd1;
          mode_d    = MODE_FWD;
          ticks_d   = '0;
          phase_d   = '0;
        end
      endcase
    end
  end

  assign push_o      = accept & (nfr != 2'd0);
  assign cmd_o.frames = fr_d;
  assign cmd_o.cnt    = nfr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_STOP;
      ticks_q <= '0;
      phase_q <= '0;
      hits_q  <= '0;
      left_q  <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      ticks_q <= ticks_d;
      phase_q <= phase_d;
      hits_q  <= hits_d;
      left_q  <= left_d;
    end
  end

endmodule

// File: rtl/core/badseq_cmdq.sv
// Two-entry command queue between front and back end.
// Depends on badseq_pkg.
`timescale 1ns / 1ps

module badseq_cmdq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  badseq_pkg::cmd_t push_cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output badseq_pkg::cmd_t head_o
);
  import badseq_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/core/badseq_back.sv
// Back end: unrolls queued commands into motor frames, one per cycle unless the output stalls.
// Two stages: speed select and boost product, then divide by 100 and clamp. Depends on badseq_pkg.
`timescale 1ns / 1ps

module badseq_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  badseq_pkg::cfg_t      cfg_i,
  input  logic                  q_valid_i,
  input  badseq_pkg::cmd_t      q_head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output badseq_pkg::out_item_t out_data_o
);
  import badseq_pkg::*;

  logic [1:0]        idx_q;
  logic              advance, take, is_last;
  frame_e            cur;
  logic              lrev, rrev;
  logic [SpeedW-1:0] lspd, rspd;
  logic [ProdW-1:0]  prod;

  logic              s1_valid_q;
  logic              s1_lrev_q, s1_rrev_q, s1_last_q;
  logic [SpeedW-1:0] s1_lspd_q;
  logic [ProdW-1:0]  s1_prod_q;

  logic              out_valid_q;
  out_item_t         out_data_q;
  logic [QuotW-1:0]  quot;
  logic [SpeedW-1:0] rspd_fin;

  assign advance = ~out_valid_q | ~out_stall_i;
  assign take    = advance & q_valid_i;
  assign cur     = q_head_i.frames[idx_q];
  assign is_last = (idx_q == (q_head_i.cnt - 2'd1));
  assign pop_o   = take & is_last;

  always_comb begin
    unique case (cur)
      FR_FWD: begin
        lrev = 1'b0; lspd = cfg_i.forward_speed;
        rrev = 1'b0; rspd = cfg_i.forward_speed;
      end
      FR_BACK: begin
        lrev = 1'b1; lspd = cfg_i.reverse_speed;
        rrev = 1'b1; rspd = cfg_i.reverse_speed;
      end
      FR_TURN_L: begin
        lrev = 1'b1; lspd = cfg_i.spin_speed;
        rrev = 1'b0; rspd = cfg_i.spin_speed;
      end
      FR_TURN_R: begin
        lrev = 1'b0; lspd = cfg_i.spin_speed;
        rrev = 1'b1; rspd = cfg_i.spin_speed;
      end
      default: begin
        lrev = 1'b0; lspd = '0;
        rrev = 1'b0; rspd = '0;
      end
    endcase
  end

  assign prod = ProdW'(rspd) * (ProdW'(BoostBase) + ProdW'(cfg_i.right_boost_pct));

  assign quot     = QuotW'(s1_prod_q[SmallW-1:0]) * QuotW'(DivRecip);
  assign rspd_fin = (s1_prod_q >= ClampProd) ? SpeedMax : SpeedW'(quot >> DivShift);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
      end
      if (advance) begin
        s1_valid_q  <= take;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_lrev_q <= lrev;
      s1_rrev_q <= rrev;
      s1_last_q <= is_last;
      s1_lspd_q <= (lspd > SpeedMax) ? SpeedMax : lspd;
      s1_prod_q <= prod;
    end
    if (advance && s1_valid_q) begin
      out_data_q.left_reverse  <= s1_lrev_q;
      out_data_q.left_speed    <= s1_lspd_q;
      out_data_q.right_reverse <= s1_rrev_q;
      out_data_q.right_speed   <= rspd_fin;
      out_data_q.last          <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/core/badseq_checker.sv
// Port-level checks of the drive sequencer, bound to the top level.
// Depends on badseq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module badseq_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input badseq_pkg::out_item_t out_data_o
);

  `BADS_ASSERT_NEXT(a_out_hold_valid, out_valid_o && out_stall_i, out_valid_o, "stalled frame dropped")
  `BADS_ASSERT_NEXT(a_out_hold_data, out_valid_o && out_stall_i, $stable(out_data_o), "stalled frame changed")
  `BADS_ASSERT_NOW(a_speed_clamp, out_valid_o, (out_data_o.left_speed <= 8'd150) && (out_data_o.right_speed <= 8'd150), "speed above clamp")
  `BADS_ASSERT_NOW(a_right_boost, out_valid_o && (out_data_o.left_reverse == out_data_o.right_reverse), out_data_o.right_speed >= out_data_o.left_speed, "right boost lowered speed")

endmodule

bind boundary_avoid_drive_sequencer_core badseq_checker u_badseq_checker (.*);
